@@ src/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int DATA_W      = 32;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
	localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic fire;
		logic load_all;
	} cell_ctrl_t;

endpackage

@@ src/lkvc_req_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_req_if
// Request channel: operation, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic signed [lkvc_pkg::DATA_W-1:0] key;
	logic signed [lkvc_pkg::DATA_W-1:0] value;

	modport source (output valid, output func, output key, output value, input ready);
	modport sink   (input valid, input func, input key, input value, output ready);
endinterface

@@ src/lkvc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// Response channel: hit flag and read value with valid/ready.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               hit;
	logic signed [lkvc_pkg::DATA_W-1:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink   (input valid, input hit, input read_value, output ready);
endinterface

@@ src/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
//
// req carries func (get/put), key and value; rsp returns hit and read_value,
// one response per request, in order. A get hit returns the stored value, a
// get miss returns -1, a put returns 0 with hit telling whether the key was
// present. Entries sit in a row of cells ordered by recency, cell 0 the most
// recent; a touched or new entry moves into cell 0 and the cells in front of
// it shift one place back, so the last cell holds the eviction victim.
// Path: request register, then the parallel compare and shift across all
// cells into the response register.
// Throughput: one request per cycle while rsp is not stalled; the compare
// and the shift of the cell row both happen together in the lookup stage.
// Reset empties every cell. While rsp is stalled, the lookup stage holds its
// request and req.ready drops once that stage is occupied.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lkvc_req_if.sink    req,
	lkvc_rsp_if.source  rsp
);

	logic                               busy_s1;
	logic                               func_s1;
	logic signed [lkvc_pkg::DATA_W-1:0] key_s1;
	logic signed [lkvc_pkg::DATA_W-1:0] value_s1;

	logic                               rsp_valid_q;
	logic                               hit_q;
	logic signed [lkvc_pkg::DATA_W-1:0] read_value_q;

	logic                               fire;
	logic                               req_acc;
	logic                               is_put;
	logic                               hit_any;
	lkvc_pkg::entry_t                   new_entry;

	lkvc_pkg::entry_t                   cell_q     [ENTRIES];
	logic                               hit_chain  [ENTRIES+1];
	logic signed [lkvc_pkg::DATA_W-1:0] val_chain  [ENTRIES+1];
	logic [ENTRIES-1:0]                 match_vec;
	logic [ENTRIES-1:0]                 valid_vec;
	logic [ENTRIES-1:0]                 valid_inc;

	assign fire      = busy_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !busy_s1 || fire;
	assign req_acc   = req.valid && req.ready;
	assign is_put    = (func_s1 == lkvc_pkg::FUNC_PUT);

	assign hit_chain[ENTRIES] = 1'b0;
	assign val_chain[ENTRIES] = lkvc_pkg::MISS_VALUE;
	assign hit_any            = hit_chain[0];

	assign new_entry = '{valid: 1'b1, key: key_s1, value: (is_put ? value_s1 : val_chain[0])};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_pkg::cell_ctrl_t ctrl;
		lkvc_pkg::entry_t     prev;

		if (i == 0) begin : g_head
			assign prev          = new_entry;
			assign ctrl.load_all = is_put;
		end else begin : g_body
			assign prev          = cell_q[i-1];
			assign ctrl.load_all = is_put && !hit_any;
		end
		assign ctrl.fire = fire;

		lkvc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key       (key_s1),
			.prev      (prev),
			.hit_in    (hit_chain[i+1]),
			.value_in  (val_chain[i+1]),
			.cur       (cell_q[i]),
			.match     (match_vec[i]),
			.hit_out   (hit_chain[i]),
			.value_out (val_chain[i])
		);

		assign valid_vec[i] = cell_q[i].valid;
	end

	assign valid_inc = valid_vec + ENTRIES'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (req_acc) begin
			busy_s1 <= 1'b1;
		end else if (fire) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_s1  <= req.func;
			key_s1   <= req.key;
			value_s1 <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q        <= hit_any;
			read_value_q <= is_put ? lkvc_pkg::PUT_VALUE : val_chain[0];
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = read_value_q;

	// occupied cells always form a contiguous run starting at cell 0
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & valid_inc) == '0)
		else $error("cell valid bits not contiguous");

	// keys stay unique, so at most one cell matches
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> $onehot0(match_vec))
		else $error("multiple cells match request key");

	// a put leaves its key as the most recent entry
	a_put_head: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_put) |=> (cell_q[0].valid && cell_q[0].key == $past(key_s1)
			&& cell_q[0].value == $past(value_s1)))
		else $error("put did not land in head cell");

	// a get hit moves the hit entry to the head without changing its value
	a_get_head: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_put && hit_any) |=> (cell_q[0].key == $past(key_s1)
			&& cell_q[0].value == read_value_q))
		else $error("get hit not moved to head cell");

	// a lookup always produces a response
	a_fire_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("lookup produced no response");

endmodule

@@ src/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency position: holds an entry, compares it against the request key,
// and loads its more recent neighbor's entry when the order shifts past it.
// ----------------------------------------------------------------------------
module lkvc_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lkvc_pkg::cell_ctrl_t               ctrl,
	input  logic signed [lkvc_pkg::DATA_W-1:0] key,
	input  lkvc_pkg::entry_t                   prev,
	input  logic                               hit_in,
	input  logic signed [lkvc_pkg::DATA_W-1:0] value_in,
	output lkvc_pkg::entry_t                   cur,
	output logic                               match,
	output logic                               hit_out,
	output logic signed [lkvc_pkg::DATA_W-1:0] value_out
);

	logic                               valid_q;
	logic signed [lkvc_pkg::DATA_W-1:0] key_q;
	logic signed [lkvc_pkg::DATA_W-1:0] value_q;
	logic                               load;

	assign match     = valid_q && (key_q == key);
	assign hit_out   = match || hit_in;
	assign value_out = match ? value_q : value_in;
	// shift when a hit sits here or older, or on a fill
	assign load      = ctrl.fire && (ctrl.load_all || hit_out);

	assign cur = '{valid: valid_q, key: key_q, value: value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

endmodule
